### rtl/isosc_pkg.sv
// Package for the interleaved sine oscillator: register map, reset values,
// parameter defaults and the quarter-wave sine table generator.
// No dependencies.
package isosc_pkg;

  // Parameter defaults handed to the top level.
  localparam int PHASE_BITS_DEF    = 32;
  localparam int ROM_ADDR_BITS_DEF = 10;
  localparam int MAX_CHANNELS_DEF  = 8;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE     = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] REG_FRAMES_TOTAL  = 2'd3;

  localparam logic [31:0] PHASE_STEP_RST    = 32'd0;
  localparam logic [15:0] AMPLITUDE_RST     = 16'd32768;
  localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd1;
  localparam logic [31:0] FRAMES_TOTAL_RST  = 32'd48000;

  localparam logic [14:0] SINE_PEAK   = 15'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Denominators (2n)(2n+1) of the Taylor terms, n = 1..8.
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Control bits that travel beside the table read.
  typedef struct packed {
    logic peak;   // second or fourth quadrant at index zero: full scale
    logic neg;    // lower half turn: negate the magnitude
  } sine_ctrl_t;

  // One quarter-wave entry, sin(pi/2 * k / 2^addr_bits) in Q1.15, from a
  // truncating Q30 Taylor series. Used at elaboration only.
  function automatic logic [15:0] sine_entry(input int k, input int addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 0; n < 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'(SINE_PEAK)) begin
      v = 64'(SINE_PEAK);
    end
    return v[15:0];
  endfunction

endpackage

### rtl/isosc_sine.sv
// Sine table read and amplitude scaling: a registered quarter-wave ROM read
// followed by a registered multiply with rounding and saturation.
// Depends on isosc_pkg.
module isosc_sine #(
  parameter int ROM_ADDR_BITS = isosc_pkg::ROM_ADDR_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,      // load the read stage
  input  logic [ROM_ADDR_BITS-1:0] addr_i,
  input  isosc_pkg::sine_ctrl_t    ctrl_i,
  input  logic                     scale_en_i,   // load the scaled sample
  input  logic [15:0]              amplitude_i,
  output logic [15:0]              sample_o
);

  localparam int RomSize = 1 << ROM_ADDR_BITS;

  typedef logic [15:0] rom_t [RomSize];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < RomSize; k++) begin
      r[k] = isosc_pkg::sine_entry(k, ROM_ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [15:0]           rom_q;
  isosc_pkg::sine_ctrl_t ctrl_q;
  logic [15:0]           sample_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rom_q  <= SineRom[addr_i];
      ctrl_q <= ctrl_i;
    end
  end

  logic [14:0] mag;
  logic [30:0] prod;
  logic [16:0] q;
  logic [15:0] sample_d;

  always_comb begin
    mag  = ctrl_q.peak ? isosc_pkg::SINE_PEAK : rom_q[14:0];
    prod = 31'(mag) * 31'(amplitude_i);
    q    = 17'((prod + 31'd16384) >> 15);
    if (ctrl_q.neg) begin
      sample_d = (q > 17'd32768) ? 16'h8000 : 16'(-q);
    end else begin
      sample_d = (q > 17'd32767) ? 16'h7fff : q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scale_en_i) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

### rtl/interleaved_sine_oscillator_top.sv
// Interleaved sine oscillator: phase accumulator, frame counter, APB
// registers, sine pipeline and the per-channel result emitter.
// Depends on isosc_pkg and isosc_sine.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         tvalid / tready            tdata[0] restart
//   m_axis    out        tvalid / tready            tdata sample, channel; tlast; tuser
//   apb       in         psel, penable, pwrite      paddr, pwdata, prdata
//
// A tick passes four registers: phase and table address, table read, scaled
// sample, then the emitter, which gives one result per cycle while
// m_axis_tready is high and holds a frame of N channels until all N are
// taken. Ticks are taken every cycle while the pipe has room, so the emitter
// sets the sustained frame rate. Ticks that yield no result leave nothing in
// the pipe. Reset clears the phase, frame count, valid bits and channel
// index, and loads the configuration registers with their reset values.
module interleaved_sine_oscillator_top #(
  parameter int PHASE_BITS    = isosc_pkg::PHASE_BITS_DEF,
  parameter int ROM_ADDR_BITS = isosc_pkg::ROM_ADDR_BITS_DEF,
  parameter int MAX_CHANNELS  = isosc_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input ticks.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] sample, [18:16] channel, [23:19] zero
  output logic        m_axis_tlast,   // last_of_frame
  output logic        m_axis_tuser,   // [0] end_of_buffer
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CntW = $clog2(MAX_CHANNELS + 1);
  localparam int ChW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IdxLsb = PHASE_BITS - 2 - ROM_ADDR_BITS;

  // Configuration registers.
  logic [31:0] phase_step_q;
  logic [15:0] amplitude_q;
  logic [3:0]  channel_count_q;
  logic [31:0] frames_total_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q    <= isosc_pkg::PHASE_STEP_RST;
      amplitude_q     <= isosc_pkg::AMPLITUDE_RST;
      channel_count_q <= isosc_pkg::CHANNEL_COUNT_RST;
      frames_total_q  <= isosc_pkg::FRAMES_TOTAL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        isosc_pkg::REG_PHASE_STEP:    phase_step_q    <= pwdata;
        isosc_pkg::REG_AMPLITUDE:     amplitude_q     <= pwdata[15:0];
        isosc_pkg::REG_CHANNEL_COUNT: channel_count_q <= pwdata[3:0];
        isosc_pkg::REG_FRAMES_TOTAL:  frames_total_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      isosc_pkg::REG_PHASE_STEP:    prdata = phase_step_q;
      isosc_pkg::REG_AMPLITUDE:     prdata = {16'd0, amplitude_q};
      isosc_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, channel_count_q};
      isosc_pkg::REG_FRAMES_TOTAL:  prdata = frames_total_q;
      default:                      prdata = 32'd0;
    endcase
  end

  // Pipeline valid bits and flow control.
  logic v1_q, v2_q, v3_q, v4_q;
  logic last4;
  logic free1, free2, free3, free4;

  assign free4 = !v4_q || (m_axis_tready && last4);
  assign free3 = !v3_q || free4;
  assign free2 = !v2_q || free3;
  assign free1 = !v1_q || free2;

  assign s_axis_tready = free1;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Phase and frame state, updated when a tick is taken.
  logic [PHASE_BITS-1:0] phase_q;
  logic [31:0]           done_q;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [31:0]           done_cur;
  logic                  produce;
  logic                  restart;

  assign restart   = s_axis_tdata[0];
  assign phase_cur = restart ? '0 : phase_q;
  assign done_cur  = restart ? 32'd0 : done_q;
  assign produce   = done_cur < frames_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      done_q  <= 32'd0;
    end else if (accept) begin
      if (produce) begin
        phase_q <= phase_cur + PHASE_BITS'(phase_step_q);
        done_q  <= done_cur + 32'd1;
      end else begin
        phase_q <= phase_cur;
        done_q  <= done_cur;
      end
    end
  end

  // Stage 1: table address, quadrant control, channel count, final flag.
  logic [1:0]               quad;
  logic [ROM_ADDR_BITS-1:0] idx;
  logic [CntW-1:0]          cc_d;

  assign quad = phase_cur[PHASE_BITS-1 -: 2];
  assign idx  = phase_cur[IdxLsb +: ROM_ADDR_BITS];

  always_comb begin
    if (channel_count_q == 4'd0) begin
      cc_d = CntW'(1);
    end else if (int'(channel_count_q) > MAX_CHANNELS) begin
      cc_d = CntW'(MAX_CHANNELS);
    end else begin
      cc_d = CntW'(channel_count_q);
    end
  end

  logic [ROM_ADDR_BITS-1:0] addr1_q;
  isosc_pkg::sine_ctrl_t    ctrl1_q;
  logic [CntW-1:0]          cc1_q, cc2_q, cc3_q, cc4_q;
  logic                     fin1_q, fin2_q, fin3_q, fin4_q;

  logic load1, load2, load3, load4;
  assign load1 = accept && produce;
  assign load2 = v1_q && free2;
  assign load3 = v2_q && free3;
  assign load4 = v3_q && free4;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      // Odd quadrants read the table backward.
      addr1_q      <= quad[0] ? ROM_ADDR_BITS'(-idx) : idx;
      ctrl1_q.peak <= quad[0] && (idx == '0);
      ctrl1_q.neg  <= quad[1];
      cc1_q        <= cc_d;
      fin1_q       <= (done_cur + 32'd1) == frames_total_q;
    end
    if (load2) begin
      cc2_q  <= cc1_q;
      fin2_q <= fin1_q;
    end
    if (load3) begin
      cc3_q  <= cc2_q;
      fin3_q <= fin2_q;
    end
    if (load4) begin
      cc4_q  <= cc3_q;
      fin4_q <= fin3_q;
    end
  end

  logic [15:0] sample3;

  isosc_sine #(
    .ROM_ADDR_BITS(ROM_ADDR_BITS)
  ) u_sine (
    .clk_i      (clk_i),
    .rd_en_i    (load2),
    .addr_i     (addr1_q),
    .ctrl_i     (ctrl1_q),
    .scale_en_i (load3),
    .amplitude_i(amplitude_q),
    .sample_o   (sample3)
  );

  // Stage 4: emitter, one channel per handshake.
  logic [15:0]    sample4_q;
  logic [ChW-1:0] ch4_q;

  assign last4 = (CntW'(ch4_q) + CntW'(1)) == cc4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ch4_q <= '0;
    end else begin
      if (free1) begin
        v1_q <= load1;
      end
      if (free2) begin
        v2_q <= v1_q;
      end
      if (free3) begin
        v3_q <= v2_q;
      end
      if (free4) begin
        v4_q  <= v3_q;
        ch4_q <= '0;
      end else if (m_axis_tready) begin
        ch4_q <= ch4_q + ChW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load4) begin
      sample4_q <= sample3;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {5'd0, 3'(ch4_q), sample4_q};
  assign m_axis_tlast  = last4;
  assign m_axis_tuser  = last4 && fin4_q;

endmodule
